[rtl/core/tkc_pkg.sv]
// shared types and codes for the top-k score cache
package tkc_pkg;

    localparam int SCORE_W   = 32;
    localparam int IO_ID_W   = 16;
    localparam int SIZE_W    = 5;
    localparam int FILL_W    = 5;

    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic                       func;
        logic [IO_ID_W-1:0]         entry_id;
        logic signed [SCORE_W-1:0]  entry_score;
    } item_t;

    typedef struct packed {
        logic [IO_ID_W-1:0]         best_id;
        logic signed [SCORE_W-1:0]  best_score;
        logic [FILL_W-1:0]          fill_count;
        logic                       kept;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MIN,
        ST_UP_CMP,
        ST_DOWN_CMP,
        ST_WRITE,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR,
        DP_SET_ROOT,
        DP_APPEND,
        DP_REPLACE_ROOT,
        DP_READ_MIN,
        DP_START_DOWN,
        DP_UP_MOVE,
        DP_DOWN_MOVE,
        DP_WRITE_CARRY,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   cfg_open;
    } dp_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic can_append;
        logic at_root;
        logic first_leaf;
        logic size_one;
        logic down_none;
        logic beats_max;
        logic below_min;
        logic parent_greater;
        logic up_more;
        logic child_stop;
        logic down_more;
        logic out_busy;
    } dp_status_t;

endpackage

[rtl/core/tkc_ctrl.sv]
// sequencer for the top-k score cache: decides each step of an offer or clear
module tkc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tkc_pkg::dp_status_t   status,
    output tkc_pkg::dp_cmd_t      cmd
);
    import tkc_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = DP_NOP;
        cmd.cfg_open = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                // no size write in the cycle an item is taken
                cmd.cfg_open = !s_valid;
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.is_clear) begin
                    cmd.op     = DP_CLEAR;
                    state_next = ST_OUT;
                end else if (status.can_append) begin
                    if (status.at_root) begin
                        cmd.op     = DP_SET_ROOT;
                        state_next = ST_OUT;
                    end else begin
                        cmd.op     = DP_APPEND;
                        // slot 1 has no parent in the heap
                        state_next = status.first_leaf ? ST_WRITE : ST_UP_CMP;
                    end
                end else if (status.size_one) begin
                    cmd.op     = status.beats_max ? DP_REPLACE_ROOT : DP_NOP;
                    state_next = ST_OUT;
                end else begin
                    cmd.op     = DP_READ_MIN;
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                if (status.below_min) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.op     = DP_START_DOWN;
                    state_next = status.down_none ? ST_WRITE : ST_DOWN_CMP;
                end
            end
            ST_UP_CMP: begin
                if (status.parent_greater) begin
                    cmd.op     = DP_UP_MOVE;
                    state_next = status.up_more ? ST_UP_CMP : ST_WRITE;
                end else begin
                    cmd.op     = DP_WRITE_CARRY;
                    state_next = ST_OUT;
                end
            end
            ST_DOWN_CMP: begin
                if (status.child_stop) begin
                    cmd.op     = DP_WRITE_CARRY;
                    state_next = ST_OUT;
                end else begin
                    cmd.op     = DP_DOWN_MOVE;
                    state_next = status.down_more ? ST_DOWN_CMP : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.op     = DP_WRITE_CARRY;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.op     = DP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/tkc_dpath.sv]
// datapath of the top-k score cache: slot memory, root registers, sift walk
module tkc_dpath #(
    parameter int CAPACITY = 16,
    parameter int ID_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tkc_pkg::item_t                s_data,
    input  logic                          cfg_valid,
    input  logic [tkc_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          m_ready,
    output logic                          m_valid,
    output tkc_pkg::result_t              m_data,
    input  tkc_pkg::dp_cmd_t              cmd,
    output tkc_pkg::dp_status_t           status
);
    import tkc_pkg::*;

    localparam int SID_W = (ID_WIDTH < IO_ID_W) ? ID_WIDTH : IO_ID_W;
    localparam int FW    = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KW    = AW + 1;

    function automatic logic [FW-1:0] clamp_size(input logic [SIZE_W-1:0] sz);
        logic [FW-1:0] r;
        if (sz == '0) begin
            r = FW'(1);
        end else if (int'(sz) > CAPACITY) begin
            r = FW'(CAPACITY);
        end else begin
            r = FW'(sz);
        end
        return r;
    endfunction

    // heap slots 1 and up
    logic [SID_W-1:0]          mem_id    [CAPACITY];
    logic signed [SCORE_W-1:0] mem_score [CAPACITY];

    logic [SIZE_W-1:0]         cache_size_reg;
    logic [FW-1:0]             filled_reg, filled_next;
    logic [SID_W-1:0]          root_id_reg, root_id_next;
    logic signed [SCORE_W-1:0] root_score_reg, root_score_next;
    logic                      in_func_reg, in_func_next;
    logic [SID_W-1:0]          in_id_reg, in_id_next;
    logic signed [SCORE_W-1:0] in_score_reg, in_score_next;
    logic [SID_W-1:0]          carry_id_reg, carry_id_next;
    logic signed [SCORE_W-1:0] carry_score_reg, carry_score_next;
    logic [AW-1:0]             j_reg, j_next;
    logic [KW-1:0]             k_reg, k_next;
    logic                      kept_reg, kept_next;
    logic [SID_W-1:0]          rd_a_id_reg, rd_b_id_reg;
    logic signed [SCORE_W-1:0] rd_a_score_reg, rd_b_score_reg;
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_reg, out_next;

    logic [FW-1:0]             n_eff, n_cfg;
    logic                      cfg_fire;
    logic [AW-1:0]             raddr_a, raddr_b;
    logic                      mem_we;
    logic [SID_W-1:0]          wr_id;
    logic signed [SCORE_W-1:0] wr_score;
    logic                      beats_max;
    logic [KW-1:0]             k_plus1, c_idx, c2;
    logic                      pick_b;
    logic [SID_W-1:0]          child_id;
    logic signed [SCORE_W-1:0] child_score;

    assign n_eff    = clamp_size(cache_size_reg);
    assign n_cfg    = clamp_size(cfg_data);
    assign cfg_fire = cfg_valid && cmd.cfg_open;

    assign beats_max   = in_score_reg > root_score_reg;
    assign k_plus1     = k_reg + KW'(1);
    assign pick_b      = (k_plus1 < KW'(n_eff)) && (rd_b_score_reg < rd_a_score_reg);
    assign c_idx       = pick_b ? k_plus1 : k_reg;
    assign c2          = {c_idx[KW-2:0], 1'b0};
    assign child_id    = pick_b ? rd_b_id_reg : rd_a_id_reg;
    assign child_score = pick_b ? rd_b_score_reg : rd_a_score_reg;

    always_comb begin
        status.is_clear       = (in_func_reg == FUNC_CLEAR);
        status.can_append     = filled_reg < n_eff;
        status.at_root        = filled_reg == '0;
        status.first_leaf     = filled_reg == FW'(1);
        status.size_one       = n_eff == FW'(1);
        status.down_none      = n_eff <= FW'(2);
        status.beats_max      = beats_max;
        status.below_min      = in_score_reg < rd_a_score_reg;
        status.parent_greater = rd_a_score_reg > carry_score_reg;
        status.up_more        = (k_reg >> 1) != '0;
        status.child_stop     = carry_score_reg <= child_score;
        status.down_more      = c2 < KW'(n_eff);
        status.out_busy       = out_valid_reg && !m_ready;
    end

    always_comb begin
        filled_next      = filled_reg;
        root_id_next     = root_id_reg;
        root_score_next  = root_score_reg;
        in_func_next     = in_func_reg;
        in_id_next       = in_id_reg;
        in_score_next    = in_score_reg;
        carry_id_next    = carry_id_reg;
        carry_score_next = carry_score_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        kept_next        = kept_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        raddr_a          = '0;
        raddr_b          = '0;
        mem_we           = 1'b0;
        wr_id            = carry_id_reg;
        wr_score         = carry_score_reg;
        case (cmd.op)
            DP_LOAD: begin
                in_func_next  = s_data.func;
                in_id_next    = s_data.entry_id[SID_W-1:0];
                in_score_next = s_data.entry_score;
                kept_next     = 1'b0;
            end
            DP_CLEAR: begin
                filled_next = '0;
            end
            DP_SET_ROOT: begin
                root_id_next    = in_id_reg;
                root_score_next = in_score_reg;
                filled_next     = filled_reg + FW'(1);
                kept_next       = 1'b1;
            end
            DP_APPEND: begin
                // a new maximum takes the root and the old root is sifted instead
                if (beats_max) begin
                    carry_id_next    = root_id_reg;
                    carry_score_next = root_score_reg;
                    root_id_next     = in_id_reg;
                    root_score_next  = in_score_reg;
                end else begin
                    carry_id_next    = in_id_reg;
                    carry_score_next = in_score_reg;
                end
                j_next      = AW'(filled_reg);
                k_next      = KW'(filled_reg >> 1);
                raddr_a     = AW'(filled_reg >> 1);
                filled_next = filled_reg + FW'(1);
                kept_next   = 1'b1;
            end
            DP_REPLACE_ROOT: begin
                root_id_next    = in_id_reg;
                root_score_next = in_score_reg;
                kept_next       = 1'b1;
            end
            DP_READ_MIN: begin
                raddr_a = AW'(1);
            end
            DP_START_DOWN: begin
                if (beats_max) begin
                    carry_id_next    = root_id_reg;
                    carry_score_next = root_score_reg;
                    root_id_next     = in_id_reg;
                    root_score_next  = in_score_reg;
                end else begin
                    carry_id_next    = in_id_reg;
                    carry_score_next = in_score_reg;
                end
                j_next    = AW'(1);
                k_next    = KW'(2);
                raddr_a   = AW'(2);
                raddr_b   = AW'(3);
                kept_next = 1'b1;
            end
            DP_UP_MOVE: begin
                mem_we   = 1'b1;
                wr_id    = rd_a_id_reg;
                wr_score = rd_a_score_reg;
                j_next   = AW'(k_reg);
                k_next   = k_reg >> 1;
                raddr_a  = AW'(k_reg >> 1);
            end
            DP_DOWN_MOVE: begin
                mem_we   = 1'b1;
                wr_id    = child_id;
                wr_score = child_score;
                j_next   = AW'(c_idx);
                k_next   = c2;
                raddr_a  = AW'(c2);
                raddr_b  = AW'(c2 + KW'(1));
            end
            DP_WRITE_CARRY: begin
                mem_we = 1'b1;
            end
            DP_EMIT: begin
                out_valid_next      = 1'b1;
                out_next.best_id    = (filled_reg == '0) ? '0 : IO_ID_W'(root_id_reg);
                out_next.best_score = (filled_reg == '0) ? '0 : root_score_reg;
                out_next.fill_count = FILL_W'(filled_reg);
                out_next.kept       = kept_reg;
            end
            default: begin
            end
        endcase
        // a smaller size cuts the fill count back
        if (cfg_fire && (filled_next > n_cfg)) begin
            filled_next = n_cfg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cache_size_reg <= SIZE_W'(16);
            filled_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_fire) begin
                cache_size_reg <= cfg_data;
            end
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        root_id_reg     <= root_id_next;
        root_score_reg  <= root_score_next;
        in_func_reg     <= in_func_next;
        in_id_reg       <= in_id_next;
        in_score_reg    <= in_score_next;
        carry_id_reg    <= carry_id_next;
        carry_score_reg <= carry_score_next;
        j_reg           <= j_next;
        k_reg           <= k_next;
        kept_reg        <= kept_next;
        out_reg         <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_id[j_reg]    <= wr_id;
            mem_score[j_reg] <= wr_score;
        end
        rd_a_id_reg    <= mem_id[raddr_a];
        rd_a_score_reg <= mem_score[raddr_a];
        rd_b_id_reg    <= mem_id[raddr_b];
        rd_b_score_reg <= mem_score[raddr_b];
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_fill_within_size: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= n_eff)
        else $error("fill count above effective size");

    a_down_moves_deeper: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_DOWN_MOVE) |-> (KW'(j_reg) < c_idx))
        else $error("sift down does not move to a child");

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_EMIT) |-> !(out_valid_reg && !m_ready))
        else $error("result overwritten before taken");

endmodule

[rtl/core/top_k_score_cache.sv]
// top level of the top-k score cache
// Keeps the best scoring (id, score) pairs, up to cache_size entries (clamped to 1..CAPACITY).
// Input channel s_valid/s_ready/s_data: func 0 offers an entry, func 1 clears.
// Result channel m_valid/m_ready/m_data: one result per item with the best
// entry, the fill count and whether the offered entry was kept.
// Config channel cfg_valid/cfg_ready/cfg_data writes cache_size; it is open
// only while no item is in progress, and a smaller size trims the fill count.
// From accept to m_valid a clear or a root update passes ST_DECIDE and
// ST_OUT; other offers also pass ST_MIN, ST_WRITE or the sift walk, one
// heap level per cycle through the slot memory (two read ports, one
// write port). One item is worked on at a time; the next is accepted in the
// cycle after the result register is loaded.
// After reset the cache is empty, cache_size is 16 and no result is pending.
// If the receiver stalls, the result holds in the output register; a further
// item is still accepted and worked, then waits until the register frees.
module top_k_score_cache #(
    parameter int CAPACITY = 16,
    parameter int ID_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tkc_pkg::item_t                s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tkc_pkg::result_t              m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tkc_pkg::SIZE_W-1:0]    cfg_data
);
    import tkc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tkc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tkc_dpath #(
        .CAPACITY (CAPACITY),
        .ID_WIDTH (ID_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

    assign cfg_ready = cmd.cfg_open;

endmodule

[tb/testbench.sv]
// self-checking testbench for the top-k score cache
`timescale 1ns / 100ps

module testbench;
    import tkc_pkg::*;

    localparam int SLOTS = 16;
    localparam int RANDOM_ITEMS = 1350;
    localparam int SETTLE_CYCLES = 20;

    // keeps its own copy of the cache and the results it must produce
    class score_cache_board;
        logic [IO_ID_W-1:0]        ids[SLOTS];
        logic signed [SCORE_W-1:0] scores[SLOTS];
        int unsigned               fill;
        logic [SIZE_W-1:0]         size_reg;
        result_t                   best_due[$];
        int unsigned               errors;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                ids[s] = '0;
                scores[s] = '0;
            end
            fill = 0;
            size_reg = 5'd16;
            errors = 0;
        endfunction

        function int unsigned live_size();
            int unsigned n;
            n = 32'(size_reg);
            if (n < 1) n = 1;
            if (n > SLOTS) n = SLOTS;
            return n;
        endfunction

        function void set_size(logic [SIZE_W-1:0] v);
            size_reg = v;
            if (fill > live_size()) fill = live_size();
        endfunction

        function void put(int pos, logic [IO_ID_W-1:0] id, logic signed [SCORE_W-1:0] sc);
            ids[pos] = id;
            scores[pos] = sc;
        endfunction

        // new entry at the tail: trade places with the maximum if larger, then sift up
        function void append(int i, logic [IO_ID_W-1:0] id, logic signed [SCORE_W-1:0] sc);
            int j;
            int k;
            put(i, id, sc);
            if (i == 0) return;
            if (sc > scores[0]) begin
                put(i, ids[0], scores[0]);
                put(0, id, sc);
                id = ids[i];
                sc = scores[i];
            end
            j = i;
            k = j / 2;
            while (k > 0 && scores[k] > sc) begin
                put(j, ids[k], scores[k]);
                j = k;
                k = k / 2;
            end
            put(j, id, sc);
        endfunction

        // full cache: evict the minimum, carried entry sifts down from slot 1
        function bit offer_full(int n, logic [IO_ID_W-1:0] id,
                                logic signed [SCORE_W-1:0] sc);
            logic [IO_ID_W-1:0]        cid;
            logic signed [SCORE_W-1:0] csc;
            int j;
            int k;
            if (n == 1) begin
                if (sc > scores[0]) begin
                    put(0, id, sc);
                    return 1'b1;
                end
                return 1'b0;
            end
            if (sc < scores[1]) return 1'b0;
            cid = id;
            csc = sc;
            if (sc > scores[0]) begin
                cid = ids[0];
                csc = scores[0];
                put(0, id, sc);
            end
            j = 1;
            k = 2;
            while (k < n) begin
                if (k + 1 < n && scores[k] > scores[k + 1]) k++;
                if (csc <= scores[k]) break;
                put(j, ids[k], scores[k]);
                j = k;
                k = k * 2;
            end
            put(j, cid, csc);
            return 1'b1;
        endfunction

        function void absorb_item(item_t it);
            result_t                   want;
            int unsigned               n;
            bit                        kept;
            logic signed [SCORE_W-1:0] sc;
            n = live_size();
            kept = 1'b0;
            sc = it.entry_score;
            if (fill > n) fill = n;
            if (it.func == FUNC_CLEAR) begin
                fill = 0;
            end else if (fill < n) begin
                append(fill, it.entry_id, sc);
                fill++;
                kept = 1'b1;
            end else begin
                kept = offer_full(n, it.entry_id, sc);
            end
            want.best_id    = (fill == 0) ? '0 : ids[0];
            want.best_score = (fill == 0) ? '0 : scores[0];
            want.fill_count = fill[FILL_W-1:0];
            want.kept       = kept;
            best_due.push_back(want);
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_best(result_t got);
            result_t want;
            if (best_due.size() == 0) begin
                report_mismatch("unrequested result", got, 0);
            end else begin
                want = best_due.pop_front();
                if (got.best_id !== want.best_id)
                    report_mismatch("best_id", got.best_id, want.best_id);
                if (got.best_score !== want.best_score)
                    report_mismatch("best_score", got.best_score, want.best_score);
                if (got.fill_count !== want.fill_count)
                    report_mismatch("fill_count", got.fill_count, want.fill_count);
                if (got.kept !== want.kept)
                    report_mismatch("kept", got.kept, want.kept);
            end
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    item_t             s_data;
    logic              m_valid;
    logic              m_ready;
    result_t           m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data;

    score_cache_board board;
    bit               steady;
    int unsigned      sent;

    top_k_score_cache DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function item_t make_offer(logic [IO_ID_W-1:0] id, logic [SCORE_W-1:0] sc);
        item_t it;
        it.func        = FUNC_OFFER;
        it.entry_id    = id;
        it.entry_score = sc;
        return it;
    endfunction

    function item_t make_clear();
        item_t it;
        it.func        = FUNC_CLEAR;
        it.entry_id    = IO_ID_W'($urandom);
        it.entry_score = $urandom;
        return it;
    endfunction

    function item_t random_item();
        logic [SCORE_W-1:0] sc;
        int unsigned        r;
        if ($urandom_range(0, 99) < 3) return make_clear();
        r = $urandom_range(0, 9);
        // narrow ranges give plenty of ties with the heap minimum and the maximum
        if (r < 4) sc = $urandom_range(0, 16) - 8;
        else if (r < 6) sc = ($urandom_range(0, 2000) - 1000) << 8;
        else if (r < 9) sc = $urandom;
        else begin
            case ($urandom_range(0, 3))
                0: sc = 32'h8000_0000;
                1: sc = 32'h7FFF_FFFF;
                2: sc = 32'h0000_0000;
                default: sc = 32'hFFFF_FFFF;
            endcase
        end
        return make_offer(IO_ID_W'($urandom), sc);
    endfunction

    task push_item(item_t it);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.absorb_item(it);
        sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // let every result come back, then give the block time to go idle
    task drain();
        s_valid <= 1'b0;
        while (board.best_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_size(logic [SIZE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_size(v);
        cfg_valid <= 1'b0;
    endtask

    function logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            case ($urandom_range(0, 3))
                0: return 5'd0;
                1: return 5'd1;
                2: return 5'd16;
                default: return 5'd31;
            endcase
        end
        if (r < 3) return SIZE_W'($urandom_range(17, 30));
        return SIZE_W'($urandom_range(1, 16));
    endfunction

    // receiver stalls
    initial begin
        int unsigned hold;
        hold = 0;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 25) hold = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            board.check_best(m_data);
    end

    initial begin
        int unsigned count;
        board = new();
        steady = 1'b0;
        sent = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty cache, field extremes and a clear at the reset size
        push_item(make_offer(16'h0000, 32'h0000_0000));
        push_item(make_offer(16'hFFFF, 32'h7FFF_FFFF));
        push_item(make_offer(16'h0001, 32'h8000_0000));
        push_item(make_clear());
        push_item(make_offer(16'h1234, 32'hFFFF_FFFF));
        drain();

        // three entries: ties with the minimum and the maximum, a reject, a new maximum
        write_size(5'd3);
        push_item(make_offer(16'h0002, 32'd100));
        push_item(make_offer(16'h0003, 32'd200));
        push_item(make_offer(16'h0004, 32'd50));
        push_item(make_offer(16'h0005, 32'd50));
        push_item(make_offer(16'h0006, 32'd200));
        push_item(make_offer(16'h0007, 32'd10));
        push_item(make_offer(16'h0008, 32'd300));
        drain();

        // shrink below the fill count, then the single-entry cache
        write_size(5'd1);
        push_item(make_offer(16'h0009, 32'd300));
        push_item(make_offer(16'h000A, 32'd299));
        push_item(make_offer(16'h000B, 32'd301));
        drain();

        write_size(5'd0);
        push_item(make_offer(16'h000C, 32'h7FFF_FFFF));
        drain();

        write_size(5'd31);
        push_item(make_offer(16'h000D, 32'h8000_0000));
        push_item(make_clear());
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_size(pick_size());
            steady = ($urandom_range(0, 3) == 0);
            count = $urandom_range(5, 70);
            repeat (count) push_item(random_item());
            drain();
        end
        steady = 1'b0;

        if (board.errors == 0 && board.best_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[top_k_score_cache.f]
rtl/core/tkc_pkg.sv
rtl/core/tkc_ctrl.sv
rtl/core/tkc_dpath.sv
rtl/core/top_k_score_cache.sv
tb/testbench.sv
